// File: sv/battery_level_alarm_monitor_assert.svh
// Assertion macros for the battery level alarm monitor.
`ifndef BATTERY_LEVEL_ALARM_MONITOR_ASSERT_SVH
`define BATTERY_LEVEL_ALARM_MONITOR_ASSERT_SVH

// same-cycle implication, checked on clk with reset masked
`define BLAM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/blam_pkg.sv
// Package: types, constants and codes of the battery level alarm monitor.
package blam_pkg;

    localparam int ALARM_SLOTS = 4;
    localparam int THR_W       = 7;
    localparam int PCT_W       = 7;
    localparam int MAH_W       = 16;
    localparam int CODE_W      = 3;
    localparam int CFG_W       = THR_W * ALARM_SLOTS;
    localparam int CFG_IDX_W   = 2;

    // tenths = MUL_K * charge / capacity
    localparam int MUL_K   = 1000;
    localparam int K_W     = 10;
    localparam int PROD_W  = MAH_W + K_W;
    localparam int QUO_W   = 10;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int DEN_W   = MAH_W + QUO_W - 1;

    // (t + 5) / 10 as (x * 205) >> 11, exact for x below 1029
    localparam int RND_ADD = 5;
    localparam int RECIP   = 205;
    localparam int RECIP_W = 8;
    localparam int RECIP_SH = 11;
    localparam int RND_W   = QUO_W + 1;
    localparam int RPROD_W = RND_W + RECIP_W;

    localparam int PCT_FULL = 100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR     = 2'd2;

    // health codes
    localparam logic [CODE_W-1:0] HEALTH_GOOD    = 3'd0;
    localparam logic [CODE_W-1:0] HEALTH_HOT     = 3'd3;
    localparam logic [CODE_W-1:0] HEALTH_DISC    = 3'd4;
    localparam logic [CODE_W-1:0] HEALTH_UNKNOWN = 3'd5;
    localparam logic [CODE_W-1:0] HEALTH_ERROR   = 3'd6;

    // charge state codes
    localparam logic [CODE_W-1:0] CST_CHARGING = 3'd1;
    localparam logic [CODE_W-1:0] CST_FULL     = 3'd2;
    localparam logic [CODE_W-1:0] CST_UNKNOWN  = 3'd4;
    localparam logic [CODE_W-1:0] CST_ERROR    = 3'd5;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_HIGH = 2'd1,
        KIND_LOW  = 2'd2
    } kind_t;

    typedef struct packed {
        logic              battery_present;
        logic [MAH_W-1:0]  charge_mah;
        logic [MAH_W-1:0]  capacity_mah;
        logic [CODE_W-1:0] health_reading;
        logic [CODE_W-1:0] charge_state_reading;
    } in_word_t;

    typedef struct packed {
        logic [PCT_W-1:0]       percent;
        logic                   is_charging;
        logic [CODE_W-1:0]      health;
        logic [CODE_W-1:0]      charge_state;
        logic                   health_changed;
        logic                   charge_state_changed;
        logic [ALARM_SLOTS-1:0] high_alarm_mask;
        logic [ALARM_SLOTS-1:0] low_alarm_mask;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [MAH_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: sv/blam_div.sv
// Restoring serial divider, one quotient bit per cycle (quotient known to fit QUO_W bits).
module blam_div (
    input  logic               clk,
    input  logic               rst_n,
    input  blam_pkg::div_req_t req,
    output blam_pkg::div_rsp_t rsp
);
    import blam_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [PROD_W-1:0] den_ext;
    logic              rem_ge;

    assign den_ext = PROD_W'(den_reg);
    assign rem_ge  = (rem_reg >= den_ext);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W - 1);
            rem_next  = req.dividend;
            den_next  = {req.divisor, {(QUO_W-1){1'b0}}};
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (rem_ge)
            begin
                rem_next = rem_reg - den_ext;
            end
            quo_next = {quo_reg[QUO_W-2:0], rem_ge};
            den_next = den_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: sv/battery_level_alarm_monitor.sv
// Top level of the battery level alarm monitor: sequencer, state and result register.
//
// Usage:
//  - Input channel in_valid / in_stall / in_data carries one battery sample word.
//    A word is taken at a clock edge with in_valid high and in_stall low.
//  - Output channel out_valid / out_stall / out_data carries one result word per
//    sample: percent, charging flag, health and charge state codes, change flags
//    and the high / low alarm masks of the four slots.
//  - Config port: cfg_wr_en, cfg_index, cfg_data; write only while idle.
//    Index 0 alarm enables, 1 packed low thresholds, 2 packed high thresholds.
//  - Steps: a sample that needs the division passes through multiply, divider
//    start, divide, round and finish; one absent, over capacity or with capacity
//    zero goes straight to finish. One sample at a time: the next word is taken
//    only back in idle. The 10-step serial divider computes 1000*charge/capacity.
//  - in_stall is high while a sample is being worked on.
//  - A result waits in the output register while out_stall is high; the next
//    sample is still taken, and held at its last step until the register frees.
//  - Reset: nothing in flight, thresholds at 0 / 100, alarms disabled, last
//    health and charge state unknown, every slot's last alarm none.
`include "battery_level_alarm_monitor_assert.svh"

module battery_level_alarm_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  blam_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output blam_pkg::out_word_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [blam_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [blam_pkg::CFG_W-1:0]          cfg_data
);
    import blam_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_START = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_RND   = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // config
    logic [ALARM_SLOTS-1:0] alarm_enable_reg;
    logic [CFG_W-1:0]       low_thr_reg;
    logic [CFG_W-1:0]       high_thr_reg;

    // kept state
    logic [CODE_W-1:0] last_health_reg, last_cstate_reg;
    kind_t             last_kind_reg [ALARM_SLOTS];
    kind_t             last_kind_next [ALARM_SLOTS];

    // working sample
    logic [MAH_W-1:0]  charge_reg, charge_next;
    logic [MAH_W-1:0]  cap_reg, cap_next;
    logic [CODE_W-1:0] health_reg, health_next;
    logic [CODE_W-1:0] cstate_reg, cstate_next;
    logic [PCT_W-1:0]  pct_reg, pct_next;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // result register
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                   in_take;
    logic                   out_free;
    logic                   fin_load;
    logic [RND_W-1:0]       rnd_sum;
    logic [RPROD_W-1:0]     rnd_prod;
    logic [ALARM_SLOTS-1:0] hi_mask, lo_mask;
    logic [ALARM_SLOTS-1:0] en_rise;

    blam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start    = (state_reg == ST_START);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = cap_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign fin_load = (state_reg == ST_FIN) && out_free;

    // round half up: (tenths + 5) / 10
    assign rnd_sum  = RND_W'(div_rsp.quotient) + RND_W'(RND_ADD);
    assign rnd_prod = RPROD_W'(rnd_sum) * RPROD_W'(RECIP);

    // alarm slots, evaluated on the final percentage
    always_comb
    begin
        logic [THR_W-1:0] hi_thr;
        logic [THR_W-1:0] lo_thr;
        logic             slot_ok;
        hi_mask = '0;
        lo_mask = '0;
        for (int i = 0; i < ALARM_SLOTS; i++)
        begin
            hi_thr  = high_thr_reg[i*THR_W +: THR_W];
            lo_thr  = low_thr_reg[i*THR_W +: THR_W];
            slot_ok = alarm_enable_reg[i] && (hi_thr <= THR_W'(PCT_FULL))
                      && (hi_thr >= lo_thr);
            if (slot_ok)
            begin
                if ((pct_reg > hi_thr) && (last_kind_reg[i] != KIND_HIGH))
                begin
                    hi_mask[i] = 1'b1;
                end
                else if ((pct_reg < lo_thr) && (last_kind_reg[i] != KIND_LOW))
                begin
                    lo_mask[i] = 1'b1;
                end
            end
        end
    end

    assign en_rise = cfg_data[ALARM_SLOTS-1:0] & ~alarm_enable_reg;

    always_comb
    begin
        for (int i = 0; i < ALARM_SLOTS; i++)
        begin
            last_kind_next[i] = last_kind_reg[i];
            if (cfg_wr_en && (cfg_index == CFG_ALARM_ENABLE) && en_rise[i])
            begin
                last_kind_next[i] = KIND_NONE;
            end
            else if (fin_load && hi_mask[i])
            begin
                last_kind_next[i] = KIND_HIGH;
            end
            else if (fin_load && lo_mask[i])
            begin
                last_kind_next[i] = KIND_LOW;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        charge_next = charge_reg;
        cap_next    = cap_reg;
        health_next = health_reg;
        cstate_next = cstate_reg;
        pct_next    = pct_reg;
        prod_next   = prod_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    charge_next = in_data.charge_mah;
                    cap_next    = in_data.capacity_mah;
                    pct_next    = '0;
                    state_next  = ST_FIN;
                    if (!in_data.battery_present)
                    begin
                        health_next = HEALTH_DISC;
                        cstate_next = CST_UNKNOWN;
                    end
                    else
                    begin
                        health_next = (in_data.health_reading <= HEALTH_HOT) ?
                                      in_data.health_reading : HEALTH_ERROR;
                        cstate_next = (in_data.charge_state_reading <= CST_UNKNOWN) ?
                                      in_data.charge_state_reading : CST_ERROR;
                        if (in_data.charge_mah > in_data.capacity_mah)
                        begin
                            pct_next = PCT_W'(PCT_FULL);
                        end
                        else if (in_data.capacity_mah != '0)
                        begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(charge_reg) * PROD_W'(MUL_K);
                state_next = ST_START;
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                pct_next   = rnd_prod[RECIP_SH +: PCT_W];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fin_load)
        begin
            out_valid_next                     = 1'b1;
            out_data_next.percent              = pct_reg;
            out_data_next.is_charging          = (cstate_reg == CST_CHARGING)
                                                 || (cstate_reg == CST_FULL);
            out_data_next.health               = health_reg;
            out_data_next.charge_state         = cstate_reg;
            out_data_next.health_changed       = (health_reg != last_health_reg);
            out_data_next.charge_state_changed = (cstate_reg != last_cstate_reg);
            out_data_next.high_alarm_mask      = hi_mask;
            out_data_next.low_alarm_mask       = lo_mask;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            alarm_enable_reg <= '0;
            low_thr_reg      <= '0;
            high_thr_reg     <= {ALARM_SLOTS{THR_W'(PCT_FULL)}};
            last_health_reg  <= HEALTH_UNKNOWN;
            last_cstate_reg  <= CST_UNKNOWN;
            for (int i = 0; i < ALARM_SLOTS; i++)
            begin
                last_kind_reg[i] <= KIND_NONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < ALARM_SLOTS; i++)
            begin
                last_kind_reg[i] <= last_kind_next[i];
            end
            if (fin_load)
            begin
                last_health_reg <= health_reg;
                last_cstate_reg <= cstate_reg;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ALARM_ENABLE: alarm_enable_reg <= cfg_data[ALARM_SLOTS-1:0];
                    CFG_LOW_THR:      low_thr_reg      <= cfg_data;
                    CFG_HIGH_THR:     high_thr_reg     <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        charge_reg   <= charge_next;
        cap_reg      <= cap_next;
        health_reg   <= health_next;
        cstate_reg   <= cstate_next;
        pct_reg      <= pct_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `BLAM_ASSERT_NEXT(a_take_leaves_idle, in_take, state_reg != ST_IDLE,
        "accepted word did not start the sequencer")
    `BLAM_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_reg == ST_DIV,
        "divider finished outside the divide step")
    `BLAM_ASSERT_IMPL(a_pct_range, out_valid_reg, out_data_reg.percent <= PCT_W'(PCT_FULL),
        "percentage above full scale")
    `BLAM_ASSERT_IMPL(a_masks_disjoint, out_valid_reg,
        (out_data_reg.high_alarm_mask & out_data_reg.low_alarm_mask) == '0,
        "slot fired high and low on one word")

endmodule
